// File: sv/sprite_motion_animator_defines.svh
// Assertion macros shared by the sprite motion animator RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SPRITE_MOTION_ANIMATOR_DEFINES_SVH
`define SPRITE_MOTION_ANIMATOR_DEFINES_SVH

// Checked only outside reset.
`define SMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sma_pkg.sv
// Types, codes and constants of the sprite motion animator.
// Used by sprite_motion_animator and its testbench; depends on nothing.
package sma_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned DUR_BITS      = 24;
  localparam int unsigned PERIOD_BITS   = 16;
  localparam int unsigned FRAC_BITS_DEF = 24;

  localparam logic [PERIOD_BITS-1:0] FRAME_PERIOD_RESET = PERIOD_BITS'(33);

  typedef enum logic [2:0] {
    OP_MOVE_TO    = 3'd0,
    OP_TRANSLATE  = 3'd1,
    OP_ANIMATE_TO = 3'd2,
    OP_FRAME_TICK = 3'd3,
    OP_SHOW       = 3'd4,
    OP_HIDE       = 3'd5
  } sma_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FRAMES,
    ST_STEP_X,
    ST_STEP_Y,
    ST_TICK_ROUND,
    ST_DONE
  } sma_state_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic signed [COORD_BITS-1:0] x_value;
    logic signed [COORD_BITS-1:0] y_value;
    logic [DUR_BITS-1:0]          duration_ms;
  } sma_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         is_shown;
    logic                         is_moving;
  } sma_out_t;

endpackage

// File: sv/sprite_motion_animator.sv
// Sprite motion animator: position, visibility and linear animation of one sprite.
// Depends on sma_pkg, sma_divider and sprite_motion_animator_defines.svh.
//
// One beat in gives one beat out. move_to, translate, show, hide and an idle
// frame_tick pass through the accept, execute and result states. An active
// frame_tick adds a state that rounds the accumulators. animate_to runs three
// divisions on one shared restoring divider that yields one quotient bit per
// cycle: a 24-bit quotient for the frame count, then a (17 + FRAC_BITS)-bit
// quotient for each axis step, each taken in the state that awaits it. A result
// that still waits downstream holds the block in its result state. The input is
// ready only between items.
`include "sprite_motion_animator_defines.svh"

module sprite_motion_animator #(
  parameter int unsigned FRAC_BITS = sma_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sma_pkg::PERIOD_BITS-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sma_pkg::sma_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sma_pkg::sma_out_t                  out_data
);

  localparam int unsigned C            = sma_pkg::COORD_BITS;
  localparam int unsigned D            = sma_pkg::DUR_BITS;
  localparam int unsigned P            = sma_pkg::PERIOD_BITS;
  localparam int unsigned ACC_BITS     = C + FRAC_BITS + 1;
  localparam int unsigned STEP_BITS    = ACC_BITS + 1;
  localparam int unsigned DIV_CNT_BITS = $clog2(ACC_BITS + 1);

  sma_pkg::sma_state_t state, state_next;

  logic [P-1:0]         frame_period;
  logic [2:0]           op_q;
  logic [C-1:0]         xv_q, yv_q;
  logic [D-1:0]         dur_q;
  logic [C-1:0]         pos_x, pos_y, goal_x, goal_y;
  logic [ACC_BITS-1:0]  acc_x, acc_y;
  logic [STEP_BITS-1:0] step_x, step_y;
  logic [D-1:0]         frames_left;
  logic                 moving, shown;

  logic                    div_start, div_done;
  logic [ACC_BITS-1:0]     div_dividend, div_quotient;
  logic [D-1:0]            div_divisor;
  logic [DIV_CNT_BITS-1:0] div_iters;

  logic [P-1:0]         period_eff;
  logic [D-1:0]         frames_calc;
  logic signed [C:0]    dx, dy;
  logic [C:0]           mag_x, mag_y;
  logic [STEP_BITS-1:0] step_calc_x, step_calc_y;
  logic                 out_free;

  function automatic logic [ACC_BITS-1:0] acc_of(input logic [C-1:0] v);
    return {v[C-1], v, {FRAC_BITS{1'b0}}};
  endfunction

  // Round half away from zero on the magnitude, then wrap to the coordinate width.
  function automatic logic [C-1:0] round_acc(input logic [ACC_BITS-1:0] a);
    logic [ACC_BITS-1:0] m;
    logic [ACC_BITS-1:0] r;
    m = a[ACC_BITS-1] ? -a : a;
    r = (m + (ACC_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (a[ACC_BITS-1]) begin
      r = -r;
    end
    return r[C-1:0];
  endfunction

  // A nonzero delta whose step truncates to zero moves one whole pixel per frame.
  function automatic logic [STEP_BITS-1:0] make_step(input logic [ACC_BITS-1:0] q,
                                                     input logic [C:0] mag,
                                                     input logic neg);
    logic [STEP_BITS-1:0] s;
    s = {1'b0, q};
    if (q == '0 && mag != '0) begin
      s = STEP_BITS'(1) << FRAC_BITS;
    end
    return neg ? -s : s;
  endfunction

  always_comb begin
    period_eff  = (frame_period == '0) ? P'(1) : frame_period;
    frames_calc = (div_quotient == '0) ? D'(1) : div_quotient[D-1:0];
    dx          = $signed({goal_x[C-1], goal_x}) - $signed({pos_x[C-1], pos_x});
    dy          = $signed({goal_y[C-1], goal_y}) - $signed({pos_y[C-1], pos_y});
    mag_x       = dx[C] ? -dx : dx;
    mag_y       = dy[C] ? -dy : dy;
    step_calc_x = make_step(div_quotient, mag_x, dx[C]);
    step_calc_y = make_step(div_quotient, mag_y, dy[C]);
    out_free    = !out_valid || out_ready;
  end

  sma_divider #(
    .DIVIDEND_BITS (ACC_BITS),
    .DIVISOR_BITS  (D)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = {mag_x, {FRAC_BITS{1'b0}}};
    div_divisor  = frames_calc;
    div_iters    = DIV_CNT_BITS'(ACC_BITS);
    unique case (state)
      sma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = sma_pkg::ST_EXEC;
        end
      end
      sma_pkg::ST_EXEC: begin
        // The duration sits at the top so that D iterations leave the frame count.
        div_dividend = {dur_q, {(ACC_BITS - D){1'b0}}};
        div_divisor  = {{(D - P){1'b0}}, period_eff};
        div_iters    = DIV_CNT_BITS'(D);
        state_next   = sma_pkg::ST_DONE;
        case (op_q)
          sma_pkg::OP_ANIMATE_TO: begin
            div_start  = 1'b1;
            state_next = sma_pkg::ST_FRAMES;
          end
          sma_pkg::OP_FRAME_TICK: begin
            if (shown && moving) begin
              state_next = sma_pkg::ST_TICK_ROUND;
            end
          end
          default: begin
          end
        endcase
      end
      sma_pkg::ST_FRAMES: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = sma_pkg::ST_STEP_X;
        end
      end
      sma_pkg::ST_STEP_X: begin
        div_dividend = {mag_y, {FRAC_BITS{1'b0}}};
        div_divisor  = frames_left;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = sma_pkg::ST_STEP_Y;
        end
      end
      sma_pkg::ST_STEP_Y: begin
        div_divisor = frames_left;
        if (div_done) begin
          state_next = sma_pkg::ST_DONE;
        end
      end
      sma_pkg::ST_TICK_ROUND: begin
        state_next = sma_pkg::ST_DONE;
      end
      sma_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= sma_pkg::FRAME_PERIOD_RESET;
      pos_x        <= '0;
      pos_y        <= '0;
      acc_x        <= '0;
      acc_y        <= '0;
      step_x       <= '0;
      step_y       <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
      frames_left  <= '0;
      moving       <= 1'b0;
      shown        <= 1'b1;
    end else begin
      if (cfg_we) begin
        frame_period <= cfg_data;
      end
      case (state)
        sma_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_q  <= in_data.op;
            xv_q  <= in_data.x_value;
            yv_q  <= in_data.y_value;
            dur_q <= in_data.duration_ms;
          end
        end
        sma_pkg::ST_EXEC: begin
          case (op_q)
            sma_pkg::OP_MOVE_TO: begin
              pos_x <= xv_q;
              pos_y <= yv_q;
              acc_x <= acc_of(xv_q);
              acc_y <= acc_of(yv_q);
            end
            sma_pkg::OP_TRANSLATE: begin
              pos_x <= pos_x + xv_q;
              pos_y <= pos_y + yv_q;
              acc_x <= acc_x + acc_of(xv_q);
              acc_y <= acc_y + acc_of(yv_q);
            end
            sma_pkg::OP_ANIMATE_TO: begin
              goal_x <= xv_q;
              goal_y <= yv_q;
            end
            sma_pkg::OP_FRAME_TICK: begin
              if (shown && moving) begin
                acc_x <= acc_x + step_x[ACC_BITS-1:0];
                acc_y <= acc_y + step_y[ACC_BITS-1:0];
              end
            end
            sma_pkg::OP_SHOW: begin
              shown <= 1'b1;
            end
            sma_pkg::OP_HIDE: begin
              shown <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        sma_pkg::ST_FRAMES: begin
          if (div_done) begin
            frames_left <= frames_calc;
            moving      <= 1'b1;
          end
        end
        sma_pkg::ST_STEP_X: begin
          if (div_done) begin
            step_x <= step_calc_x;
          end
        end
        sma_pkg::ST_STEP_Y: begin
          if (div_done) begin
            step_y <= step_calc_y;
          end
        end
        sma_pkg::ST_TICK_ROUND: begin
          frames_left <= frames_left - D'(1);
          if (frames_left == D'(1)) begin
            // Last frame lands exactly on the goal.
            moving <= 1'b0;
            pos_x  <= goal_x;
            pos_y  <= goal_y;
            acc_x  <= acc_of(goal_x);
            acc_y  <= acc_of(goal_y);
          end else begin
            pos_x <= round_acc(acc_x);
            pos_y <= round_acc(acc_y);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result register lets the next beat in while this one waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sma_pkg::ST_DONE && out_free) begin
      out_valid          <= 1'b1;
      out_data.out_x     <= pos_x;
      out_data.out_y     <= pos_y;
      out_data.is_shown  <= shown;
      out_data.is_moving <= moving;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `SMA_ASSERT_ALWAYS(a_moving_has_frames, moving |-> frames_left != '0, "moving with no frames left")
  `SMA_ASSERT(a_div_done_expected, div_done |-> (state == sma_pkg::ST_FRAMES || state == sma_pkg::ST_STEP_X || state == sma_pkg::ST_STEP_Y), "divider finished while not awaited")
  `SMA_ASSERT(a_accept_to_exec, (in_valid && in_ready) |=> state == sma_pkg::ST_EXEC, "accepted beat not executed")
  `SMA_ASSERT(a_last_frame_snaps, (state == sma_pkg::ST_TICK_ROUND && frames_left == D'(1)) |=> (!moving && pos_x == goal_x && pos_y == goal_y), "last frame did not reach the goal")

endmodule

// File: sv/sma_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; shared by the frame count and both step divisions.
module sma_divider #(
  parameter int unsigned DIVIDEND_BITS = 41,
  parameter int unsigned DIVISOR_BITS  = 24,
  localparam int unsigned CNT_BITS     = $clog2(DIVIDEND_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  input  logic [CNT_BITS-1:0]      iters,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  dsr;
  logic [CNT_BITS-1:0]      cnt;
  logic                     busy;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // The dividend shifts out of the top of quo while quotient bits enter at the bottom.
  always_comb begin
    trial = {rem, quo[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dsr};
    fits  = !diff[DIVISOR_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], fits};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: bench/sprite_motion_animator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sprite_motion_animator: directed table, then paced random phases.
// Depends on sma_pkg and the sprite_motion_animator RTL; reads no files.
module sprite_motion_animator_tb;

  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef logic signed [40:0] fix_t;  // position, 24 fraction bits
  typedef logic signed [41:0] vel_t;  // per-frame step, 24 fraction bits

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum bit {CHK_MODEL, CHK_TYPED} row_chk_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] op;
    int         x;
    int         y;
    int         dur;   // frame period for configuration rows
    row_chk_t   chk;
    int         ex;
    int         ey;
    bit         esh;
    bit         emv;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  logic [sma_pkg::PERIOD_BITS-1:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  sma_pkg::sma_in_t   in_data;
  logic      out_valid;
  logic      out_ready;
  sma_pkg::sma_out_t  out_data;

  sprite_motion_animator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predicted sprite state.
  logic [15:0]        period_ms;
  logic signed [15:0] spr_x, spr_y, dest_x, dest_y;
  fix_t               fx_x, fx_y;
  vel_t               vel_x, vel_y;
  logic [23:0]        ticks_to_go;
  bit                 in_motion, visible;

  sma_pkg::sma_out_t sprite_due[$];
  int       faults;
  int       results_checked;
  int       goals_reached;
  int       op_seen[8];
  int       tx_idle_pct;
  int       rx_stall_pct;

  dir_row_t dir_rows[27] = '{
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,      0,      0, 1, 0},
    '{ROW_ITEM, sma_pkg::OP_MOVE_TO,    32767, -32768,        0, CHK_TYPED,  32767, -32768, 1, 0},
    '{ROW_ITEM, sma_pkg::OP_TRANSLATE,      1,     -1,        0, CHK_TYPED, -32768,  32767, 1, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO, 32767, -32768,        0, CHK_TYPED, -32768,  32767, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,  32767, -32768, 1, 0},
    '{ROW_ITEM, OP_RSVD_LO,       -1,     -1, 16777215, CHK_TYPED,  32767, -32768, 1, 0},
    '{ROW_ITEM, OP_RSVD_HI,        0,      0,        0, CHK_TYPED,  32767, -32768, 1, 0},
    '{ROW_ITEM, sma_pkg::OP_HIDE,           0,      0,        0, CHK_TYPED,  32767, -32768, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO,     0,      0,      330, CHK_TYPED,  32767, -32768, 0, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,  32767, -32768, 0, 1},
    '{ROW_ITEM, sma_pkg::OP_SHOW,           0,      0,        0, CHK_TYPED,  32767, -32768, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_MOVE_TO,      100,    100,        0, CHK_TYPED,    100,    100, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_TRANSLATE,     -5,      7,        0, CHK_TYPED,     95,    107, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_CFG,  sma_pkg::OP_MOVE_TO,        0,      0,        1, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO,-32768,  32767, 16777215, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_CFG,  sma_pkg::OP_MOVE_TO,        0,      0,        0, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO,     0,      0,        2, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,      0,      0, 1, 0},
    '{ROW_CFG,  sma_pkg::OP_MOVE_TO,        0,      0,    65535, CHK_MODEL,      0,      0, 0, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO,     5,      5,    65534, CHK_TYPED,      0,      0, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,      5,      5, 1, 0},
    '{ROW_ITEM, sma_pkg::OP_ANIMATE_TO,     5,      5,    65535, CHK_TYPED,      5,      5, 1, 1},
    '{ROW_ITEM, sma_pkg::OP_FRAME_TICK,     0,      0,        0, CHK_TYPED,      5,      5, 1, 0}
  };

  always #6 clk = ~clk;

  function automatic fix_t to_fixed(input logic signed [15:0] c);
    return {c[15], c, 24'd0};
  endfunction

  function automatic fix_t fixed_add_vel(input fix_t a, input vel_t v);
    logic [41:0] sum;
    sum = {a[40], a} + v;
    return sum[40:0];
  endfunction

  // Rounds half away from zero, then wraps to the pixel grid.
  function automatic logic signed [15:0] round_to_pixel(input fix_t a);
    logic [40:0] mag;
    logic [40:0] r;
    mag = a[40] ? -a : a;
    r = (mag + (41'd1 << 23)) >> 24;
    if (a[40])
      r = -r;
    return r[15:0];
  endfunction

  // Truncates toward zero; a nonzero distance never gets a zero step.
  function automatic vel_t velocity_toward(input logic signed [15:0] dest,
                                           input logic signed [15:0] from,
                                           input logic [23:0] frames);
    logic [16:0] delta;
    logic [16:0] mag;
    logic [40:0] q;
    delta = {dest[15], dest} - {from[15], from};
    mag = delta[16] ? -delta : delta;
    q = {mag, 24'd0} / {17'd0, frames};
    if (q == 0 && mag != 0)
      q = 41'd1 << 24;
    return delta[16] ? -{1'b0, q} : {1'b0, q};
  endfunction

  function automatic sma_pkg::sma_out_t predict_sprite(input sma_pkg::sma_in_t beat);
    logic [15:0] per;
    logic [23:0] frames;
    sma_pkg::sma_out_t    res;
    case (beat.op)
      sma_pkg::OP_MOVE_TO: begin
        spr_x = beat.x_value;
        spr_y = beat.y_value;
        fx_x = to_fixed(beat.x_value);
        fx_y = to_fixed(beat.y_value);
      end
      sma_pkg::OP_TRANSLATE: begin
        spr_x = spr_x + beat.x_value;
        spr_y = spr_y + beat.y_value;
        fx_x = fx_x + to_fixed(beat.x_value);
        fx_y = fx_y + to_fixed(beat.y_value);
      end
      sma_pkg::OP_ANIMATE_TO: begin
        per = (period_ms == 0) ? 16'd1 : period_ms;
        frames = beat.duration_ms / per;
        if (frames == 0)
          frames = 24'd1;
        dest_x = beat.x_value;
        dest_y = beat.y_value;
        in_motion = 1'b1;
        ticks_to_go = frames;
        vel_x = velocity_toward(dest_x, spr_x, frames);
        vel_y = velocity_toward(dest_y, spr_y, frames);
      end
      sma_pkg::OP_FRAME_TICK: begin
        if (visible && in_motion) begin
          fx_x = fixed_add_vel(fx_x, vel_x);
          fx_y = fixed_add_vel(fx_y, vel_y);
          spr_x = round_to_pixel(fx_x);
          spr_y = round_to_pixel(fx_y);
          ticks_to_go = ticks_to_go - 24'd1;
          if (ticks_to_go == 0) begin
            in_motion = 1'b0;
            spr_x = dest_x;
            spr_y = dest_y;
            fx_x = to_fixed(dest_x);
            fx_y = to_fixed(dest_y);
            goals_reached++;
          end
        end
      end
      sma_pkg::OP_SHOW: visible = 1'b1;
      sma_pkg::OP_HIDE: visible = 1'b0;
      default: ;
    endcase
    res.out_x = spr_x;
    res.out_y = spr_y;
    res.is_shown = visible;
    res.is_moving = in_motion;
    return res;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Holds the beat until it is taken; the expectation is booked at that edge.
  task automatic offer_beat(input sma_pkg::sma_in_t beat, input bit typed,
                            input sma_pkg::sma_out_t typed_res);
    sma_pkg::sma_out_t res;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    res = predict_sprite(beat);
    sprite_due.push_back(typed ? typed_res : res);
    op_seen[beat.op]++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic signed [15:0] x,
                         input logic signed [15:0] y, input logic [23:0] dur);
    sma_pkg::sma_in_t beat;
    beat.op = op;
    beat.x_value = x;
    beat.y_value = y;
    beat.duration_ms = dur;
    offer_beat(beat, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sprite_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_ms = v;
  endtask

  // Mostly whole animations (animate, then about as many ticks as frames),
  // with side moves and visibility changes mixed in, plus bursts of noise.
  task automatic run_phase(input int beats, input int idle_pct, input int stall_pct,
                           input logic [15:0] period);
    int          sent;
    int          frames_want;
    int          eff;
    int          dur;
    bit          mid_done;
    logic [2:0]  side_op;
    write_period(period);
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    eff = (period == 0) ? 1 : period;
    sent = 0;
    mid_done = 1'b0;
    while (sent < beats) begin
      if (!mid_done && sent >= beats / 2) begin
        wait_drained();
        mid_done = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_op(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 24'($urandom));
          sent++;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send_op($urandom_range(0, 1) ? sma_pkg::OP_MOVE_TO : sma_pkg::OP_TRANSLATE,
                  pick_coord(), pick_coord(), 24'($urandom));
          sent++;
        end
        frames_want = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0)
          dur = $urandom_range(0, 24'hFFFFFF);
        else
          dur = frames_want * eff + $urandom_range(0, eff - 1);
        send_op(sma_pkg::OP_ANIMATE_TO, pick_coord(), pick_coord(), 24'(dur));
        sent++;
        repeat (frames_want + $urandom_range(0, 2)) begin
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
              0: side_op = sma_pkg::OP_MOVE_TO;
              1: side_op = sma_pkg::OP_TRANSLATE;
              2: side_op = sma_pkg::OP_SHOW;
              default: side_op = sma_pkg::OP_HIDE;
            endcase
            send_op(side_op, pick_coord(), pick_coord(), 24'($urandom));
            sent++;
          end
          send_op(sma_pkg::OP_FRAME_TICK, 16'($urandom), 16'($urandom), 24'($urandom));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_stall_pct == 0)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : check_results
    sma_pkg::sma_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (sprite_due.size() == 0) begin
        faults++;
        if (faults <= 40)
          $display("%0t: result beat with nothing expected: x=%0d y=%0d shown=%0b moving=%0b",
                   $time, out_data.out_x, out_data.out_y, out_data.is_shown,
                   out_data.is_moving);
      end else begin
        want = sprite_due.pop_front();
        results_checked++;
        if (out_data.out_x !== want.out_x) begin
          faults++;
          if (faults <= 40)
            $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, out_data.out_x);
        end
        if (out_data.out_y !== want.out_y) begin
          faults++;
          if (faults <= 40)
            $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, out_data.out_y);
        end
        if (out_data.is_shown !== want.is_shown) begin
          faults++;
          if (faults <= 40)
            $display("%0t: is_shown expected %0b actual %0b", $time, want.is_shown,
                     out_data.is_shown);
        end
        if (out_data.is_moving !== want.is_moving) begin
          faults++;
          if (faults <= 40)
            $display("%0t: is_moving expected %0b actual %0b", $time, want.is_moving,
                     out_data.is_moving);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("sprite_motion_animator regression: fail");
    $finish;
  end

  initial begin : stimulus
    sma_pkg::sma_in_t  beat;
    sma_pkg::sma_out_t typed_res;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    faults = 0;
    results_checked = 0;
    goals_reached = 0;
    period_ms = sma_pkg::FRAME_PERIOD_RESET;
    spr_x = '0;
    spr_y = '0;
    dest_x = '0;
    dest_y = '0;
    fx_x = '0;
    fx_y = '0;
    vel_x = '0;
    vel_y = '0;
    ticks_to_go = '0;
    in_motion = 1'b0;
    visible = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_period(16'(dir_rows[i].dur));
      end else begin
        beat.op = dir_rows[i].op;
        beat.x_value = 16'(dir_rows[i].x);
        beat.y_value = 16'(dir_rows[i].y);
        beat.duration_ms = 24'(dir_rows[i].dur);
        typed_res.out_x = 16'(dir_rows[i].ex);
        typed_res.out_y = 16'(dir_rows[i].ey);
        typed_res.is_shown = dir_rows[i].esh;
        typed_res.is_moving = dir_rows[i].emv;
        offer_beat(beat, dir_rows[i].chk == CHK_TYPED, typed_res);
      end
    end

    run_phase(340, 0, 0, 16'd33);
    run_phase(340, 59, 0, 16'($urandom_range(1, 1000)));
    run_phase(340, 0, 59, 16'd1);
    run_phase(340, 23, 23, 16'd65535);

    in_valid <= 1'b0;
    while (sprite_due.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (sprite_due.size() != 0)
      faults++;

    $display("Drove %0d beats (%0d animate_to, %0d frame_tick, %0d reserved ops), %0d results checked.",
             op_seen.sum(), op_seen[sma_pkg::OP_ANIMATE_TO], op_seen[sma_pkg::OP_FRAME_TICK],
             op_seen[OP_RSVD_LO] + op_seen[OP_RSVD_HI], results_checked);
    $display("%0d animations reached their goal across four pacing mixes and five frame periods.",
             goals_reached);
    if (faults == 0)
      $display("sprite_motion_animator regression: pass");
    else
      $display("sprite_motion_animator regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/sma_pkg.sv
sv/sma_divider.sv
sv/sprite_motion_animator.sv
bench/sprite_motion_animator_tb.sv
